// File: sv/assert_macros.svh
// Assertion macros shared by the RTL files.
// Stands alone; define NO_ASSERTIONS to compile the checks out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Property must hold at every clock edge outside reset.
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Expression must never be true at a clock edge outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`else

`define ASSERT_CLK(lbl, clk, rst_n, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg)

`endif

`endif

// File: sv/alr_pkg.sv
// Shared types and constants for the audio loop recorder.
// No dependencies.
package alr_pkg;

  localparam int unsigned NUM_BANKS = 3;

  typedef logic [1:0] bank_t;

  localparam bank_t RESET_RECORD_BANK = 2'd0;
  localparam bank_t RESET_TAKE_BANK   = 2'd1;
  localparam bank_t RESET_PLAY_BANK   = 2'd1;

  // Lowest bank that is neither the take nor the playing bank.
  function automatic bank_t pick_free(bank_t take, bank_t play);
    bank_t res;
    res = 2'd0;
    if (take != 2'd0 && play != 2'd0) begin
      res = 2'd0;
    end else if (take != 2'd1 && play != 2'd1) begin
      res = 2'd1;
    end else if (take != 2'd2 && play != 2'd2) begin
      res = 2'd2;
    end
    return res;
  endfunction

  // Fold an out-of-range bank code onto bank 0 (modulo three).
  function automatic bank_t fold_bank(bank_t b);
    return (b == 2'd3) ? 2'd0 : b;
  endfunction

endpackage

// File: sv/alr_bank_mem.sv
// Single-port sample memory for the three loop banks, registered read.
// Depends on alr_pkg.
module alr_bank_mem
  import alr_pkg::*;
#(
  parameter int unsigned DEPTH = 196608,
  parameter int unsigned WIDTH = 24,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write and read never fall in the same cycle (interlocked by the top level)
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: sv/audio_loop_recorder.sv
// Audio loop recorder top level: trigger handling, bank rotation, stream handshake.
// Depends on alr_pkg, alr_bank_mem and assert_macros.svh.
//
//  channel   dir  handshake                    beat contents
//  s_axis    in   s_axis_tvalid/s_axis_tready  sample_in, four trigger bits
//  m_axis    out  m_axis_tvalid/m_axis_tready  sample_out
//
// An input beat uses the single memory port twice: it writes the recorded
// sample in the accept cycle and reads the playback sample in the next one.
// The result is valid once that read cycle ends. Reset clears the control
// state; the sample store has no clearing pass (entries are read only once written).
// A new beat is taken only when the output register is empty or its beat leaves
// in that same cycle, so a stalled sink holds off the input.
module audio_loop_recorder
  import alr_pkg::*;
#(
  parameter int unsigned MAX_SAMPLES = 65536,
  parameter int unsigned SAMPLE_BITS = 24,
  localparam int unsigned IN_W  = ((SAMPLE_BITS + 4 + 7) / 8) * 8,
  localparam int unsigned OUT_W = ((SAMPLE_BITS + 7) / 8) * 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  // from bit 0: sample_in, play_begin, play_end, record_begin, record_end, zero pad
  input  logic [IN_W-1:0]  s_axis_tdata,
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  // from bit 0: sample_out, zero pad
  output logic [OUT_W-1:0] m_axis_tdata
);

`include "assert_macros.svh"

  localparam int unsigned DEPTH = NUM_BANKS * MAX_SAMPLES;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned LW    = $clog2(MAX_SAMPLES + 1);

  localparam logic [LW-1:0] LEN_MAX = LW'(MAX_SAMPLES);
  localparam logic [AW-1:0] BASE1   = AW'(MAX_SAMPLES);
  localparam logic [AW-1:0] BASE2   = AW'(2 * MAX_SAMPLES);

  function automatic logic [AW-1:0] bank_base(bank_t b);
    logic [AW-1:0] res;
    unique case (fold_bank(b))
      2'd1:    res = BASE1;
      2'd2:    res = BASE2;
      default: res = '0;
    endcase
    return res;
  endfunction

  // Input beat fields
  logic signed [SAMPLE_BITS-1:0] sample_in;
  logic play_begin, play_end, record_begin, record_end;

  assign sample_in    = s_axis_tdata[SAMPLE_BITS-1:0];
  assign play_begin   = s_axis_tdata[SAMPLE_BITS];
  assign play_end     = s_axis_tdata[SAMPLE_BITS+1];
  assign record_begin = s_axis_tdata[SAMPLE_BITS+2];
  assign record_end   = s_axis_tdata[SAMPLE_BITS+3];

  // Control state
  bank_t         rec_bank_q, rec_bank_d;
  bank_t         take_bank_q, take_bank_d;
  bank_t         play_bank_q, play_bank_d;
  logic          recording_q, recording_d;
  logic          playing_q, playing_d;
  logic          take_ready_q, take_ready_d;
  logic [LW-1:0] pos_q, pos_d;
  logic [LW-1:0] len_q [NUM_BANKS];
  logic [LW-1:0] len_d [NUM_BANKS];

  // Pipeline / handshake
  logic          rd_pend_q;   // read cycle for the accepted beat
  logic          rd_ok_q;     // beat plays a stored sample (else output zero)
  logic [AW-1:0] raddr_q;
  logic          out_valid_q;
  logic          out_zero_q;

  logic          in_fire;
  logic          wr_en, rd_en;
  logic [AW-1:0] waddr, raddr;
  logic [LW-1:0] rec_len, play_len;
  logic [SAMPLE_BITS-1:0] rdata;

  assign s_axis_tready = !rd_pend_q && (!out_valid_q || m_axis_tready);
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  // Next control state for one beat, in trigger order.
  always_comb begin
    rec_bank_d   = rec_bank_q;
    take_bank_d  = take_bank_q;
    play_bank_d  = play_bank_q;
    recording_d  = recording_q;
    playing_d    = playing_q;
    take_ready_d = take_ready_q;
    pos_d        = pos_q;
    len_d        = len_q;
    wr_en        = 1'b0;
    waddr        = '0;
    rd_en        = 1'b0;
    raddr        = '0;
    rec_len      = '0;
    play_len     = '0;

    // record triggers: stop first while recording, start first otherwise
    if (recording_q) begin
      if (record_end) begin
        recording_d  = 1'b0;
        take_bank_d  = rec_bank_d;
        take_ready_d = 1'b1;
      end
      if (record_begin) begin
        rec_bank_d                   = pick_free(take_bank_d, play_bank_d);
        len_d[fold_bank(rec_bank_d)] = '0;
        recording_d                  = 1'b1;
      end
    end else begin
      if (record_begin) begin
        rec_bank_d                   = pick_free(take_bank_d, play_bank_d);
        len_d[fold_bank(rec_bank_d)] = '0;
        recording_d                  = 1'b1;
      end
      if (record_end) begin
        recording_d  = 1'b0;
        take_bank_d  = rec_bank_d;
        take_ready_d = 1'b1;
      end
    end

    // play triggers, same ordering rule
    if (playing_q) begin
      if (play_end) begin
        playing_d = 1'b0;
      end
      if (play_begin) begin
        playing_d    = 1'b1;
        play_bank_d  = take_bank_d;
        take_ready_d = 1'b0;
        pos_d        = '0;
      end
    end else begin
      if (play_begin) begin
        playing_d    = 1'b1;
        play_bank_d  = take_bank_d;
        take_ready_d = 1'b0;
        pos_d        = '0;
      end
      if (play_end) begin
        playing_d = 1'b0;
      end
    end

    // append, dropping samples once the bank is full
    if (recording_d) begin
      rec_len = len_d[fold_bank(rec_bank_d)];
      if (rec_len < LEN_MAX) begin
        wr_en                        = 1'b1;
        waddr                        = bank_base(rec_bank_d) + AW'(rec_len);
        len_d[fold_bank(rec_bank_d)] = rec_len + LW'(1);
      end
    end

    // playback: read below the length, wrap at the length
    if (playing_d) begin
      play_len = len_d[fold_bank(play_bank_d)];
      if (pos_d < play_len) begin
        rd_en = 1'b1;
        raddr = bank_base(play_bank_d) + AW'(pos_d);
      end
      pos_d = pos_d + LW'(1);
      if (pos_d >= play_len) begin
        if (take_ready_d) begin
          play_bank_d  = take_bank_d;
          take_ready_d = 1'b0;
        end
        pos_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rec_bank_q   <= RESET_RECORD_BANK;
      take_bank_q  <= RESET_TAKE_BANK;
      play_bank_q  <= RESET_PLAY_BANK;
      recording_q  <= 1'b0;
      playing_q    <= 1'b0;
      take_ready_q <= 1'b0;
      pos_q        <= '0;
      for (int i = 0; i < NUM_BANKS; i++) begin
        len_q[i] <= '0;
      end
    end else if (in_fire) begin
      rec_bank_q   <= rec_bank_d;
      take_bank_q  <= take_bank_d;
      play_bank_q  <= play_bank_d;
      recording_q  <= recording_d;
      playing_q    <= playing_d;
      take_ready_q <= take_ready_d;
      pos_q        <= pos_d;
      len_q        <= len_d;
    end
  end

  // read request carried to the cycle after accept
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_pend_q <= 1'b0;
    end else begin
      rd_pend_q <= in_fire;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      rd_ok_q <= rd_en;
      raddr_q <= raddr;
    end
  end

  // output register; free again before the next read can land
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (rd_pend_q) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_pend_q) begin
      out_zero_q <= !rd_ok_q;
    end
  end

  alr_bank_mem #(
    .DEPTH (DEPTH),
    .WIDTH (SAMPLE_BITS)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (in_fire && wr_en),
    .waddr_i (waddr),
    .wdata_i (sample_in),
    .re_i    (rd_pend_q && rd_ok_q),
    .raddr_i (raddr_q),
    .rdata_o (rdata)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = OUT_W'(out_zero_q ? '0 : rdata);

  // write port and read port of the single-port memory never collide
  `ASSERT_NEVER(a_port_conflict, clk_i, rst_ni, rd_pend_q && in_fire,
                "memory write overlaps pending read")
  // the recording bank is never the playing or take bank
  `ASSERT_CLK(a_rec_bank_free, clk_i, rst_ni,
              !recording_q || (rec_bank_q != play_bank_q && rec_bank_q != take_bank_q),
              "recording bank shared with playback")
  // position stays inside the playing take
  `ASSERT_CLK(a_pos_range, clk_i, rst_ni,
              pos_q == '0 || pos_q < len_q[fold_bank(play_bank_q)],
              "play position beyond take length")
  // every read cycle yields a result beat
  `ASSERT_CLK(a_read_to_out, clk_i, rst_ni, rd_pend_q |=> out_valid_q,
              "read cycle without result")

endmodule
